>>> rtl/core/qrm_pkg.sv
`timescale 1ns / 1ps

package qrm_pkg;

   localparam int OUT_FRAC = 14;
   localparam int IN_FRAC  = 12;
   localparam int COMP_W   = 16;
   localparam int ENT_W    = 16;
   localparam int TOL_W    = 10;
   localparam int N_ENT    = 9;

   localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(1);

   // products, sums and numerators
   localparam int PROD_W = 2 * COMP_W;
   localparam int S_W    = PROD_W + 1;
   localparam int O_W    = PROD_W + 2;
   localparam int E_W    = S_W + 2;
   localparam int D_W    = S_W;

   // divider: quotient reaches one, so one bit above the fraction
   localparam int Q_W   = OUT_FRAC + 1;
   localparam int DVD_W = D_W + Q_W - 1;

   // norm: floor(sqrt(s << SQ_SHIFT)) lands on the output fraction directly
   localparam int SQ_SHIFT = 2 * (OUT_FRAC - IN_FRAC);
   localparam int SQ_STEPS = (S_W + SQ_SHIFT + 1) / 2;
   localparam int SQ_IN_W  = 2 * SQ_STEPS;
   localparam int SQ_REM_W = SQ_STEPS + 2;

   typedef struct packed {
      logic [S_W-1:0]        s;
      logic [S_W-1:0]        a0;
      logic [S_W-1:0]        a4;
      logic [S_W-1:0]        a8;
      logic signed [O_W-1:0] o1;
      logic signed [O_W-1:0] o2;
      logic signed [O_W-1:0] o3;
      logic signed [O_W-1:0] o5;
      logic signed [O_W-1:0] o6;
      logic signed [O_W-1:0] o7;
   } num_type;

   typedef struct packed {
      logic [N_ENT-1:0] sgn;
      logic             zero;
   } side_type;

endpackage

>>> rtl/core/qrm_div_lane.sv
`timescale 1ns / 1ps

module qrm_div_lane (
   input  logic                         clock,
   input  logic [qrm_pkg::Q_W-1:0]      en,
   input  logic [qrm_pkg::D_W-1:0]      mag,
   input  logic [qrm_pkg::D_W-1:0]      den,
   output logic [qrm_pkg::Q_W-1:0]      quo
);
   import qrm_pkg::*;

   logic [DVD_W-1:0] rem_ff [Q_W];
   logic [D_W-1:0]   den_ff [Q_W];
   logic [Q_W-1:0]   quo_ff [Q_W];

   // one quotient bit per stage, msb first; dividend carries the rounding half
   for (genvar j = 0; j < Q_W; j++) begin : g_step
      logic [DVD_W-1:0] rem_src;
      logic [D_W-1:0]   den_src;
      logic [Q_W-1:0]   quo_src;
      logic [DVD_W-1:0] dsh;
      logic             ge;
      logic [DVD_W-1:0] rem_in;
      logic [Q_W-1:0]   quo_in;

      if (j == 0) begin : g_first
         assign rem_src = (DVD_W'(mag) << OUT_FRAC) + DVD_W'(den >> 1);
         assign den_src = den;
         assign quo_src = '0;
      end else begin : g_next
         assign rem_src = rem_ff[j-1];
         assign den_src = den_ff[j-1];
         assign quo_src = quo_ff[j-1];
      end

      assign dsh    = DVD_W'(den_src) << (Q_W - 1 - j);
      assign ge     = rem_src >= dsh;
      assign rem_in = ge ? rem_src - dsh : rem_src;
      assign quo_in = {quo_src[Q_W-2:0], ge};

      always_ff @(posedge clock) begin
         if (en[j]) begin
            rem_ff[j] <= rem_in;
            den_ff[j] <= den_src;
            quo_ff[j] <= quo_in;
         end
      end
   end

   assign quo = quo_ff[Q_W-1];

endmodule

>>> rtl/core/quaternion_to_rotation_matrix.sv
`timescale 1ns / 1ps

// Quaternion (w,x,y,z, Q3.12) to 3x3 rotation matrix (Q1.14), fully pipelined.
// req_ channel: one quaternion word per accepted beat; rsp_ channel: nine
// matrix entries in rsp_tdata, rsp_tuser set when the input norm is zero
// (matrix then all zeros). csr_ channel writes the 10-bit unit tolerance;
// write it only while no word is in flight. csr_ready is always high.
// The pipeline has 3 + SQ_STEPS + 2 + Q_W + 1 = 40 register stages at the
// default widths. The length comes from the norm square root (one root bit
// per stage) and the nine dividers (one quotient bit per stage). Throughput:
// one word per cycle while rsp_tready does not stall the output.
// Every stage holds a valid bit and advances when it is empty or the stage
// after it moves, so a stall on rsp_tready fills the bubbles first and then
// drops req_tready; nothing is lost or repeated.
// Reset (synchronous, active high) empties the pipeline and sets the
// tolerance to 1.
module quaternion_to_rotation_matrix (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // comp_w, comp_x, comp_y, comp_z
   input  logic [4*qrm_pkg::COMP_W-1:0]      req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // m00, m01, m02, m10, m11, m12, m20, m21, m22
   output logic [9*qrm_pkg::ENT_W-1:0]       rsp_tdata,
   // zero_norm
   output logic                              rsp_tuser,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [qrm_pkg::TOL_W-1:0]         csr_data
);
   import qrm_pkg::*;

   localparam int P_IN   = 0;
   localparam int P_PROD = 1;
   localparam int P_SUM  = 2;
   localparam int P_SQ0  = 3;
   localparam int P_CMP  = P_SQ0 + SQ_STEPS;
   localparam int P_NUM  = P_CMP + 1;
   localparam int P_DIV0 = P_NUM + 1;
   localparam int P_OUT  = P_DIV0 + Q_W;
   localparam int NST    = P_OUT + 1;

   // handshake and stage control
   logic [NST-1:0] vld_ff;
   logic [NST:0]   en;
   logic [TOL_W-1:0] tol_ff;

   assign en[NST] = rsp_tready;
   for (genvar i = 0; i < NST; i++) begin : g_ctl
      assign en[i] = !vld_ff[i] || en[i+1];
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (en[i]) begin
            if (i == 0) begin
               vld_ff[i] <= req_tvalid;
            end else begin
               vld_ff[i] <= vld_ff[(i == 0) ? 0 : i-1];
            end
         end
      end
   end

   assign req_tready = en[P_IN];
   assign rsp_tvalid = vld_ff[P_OUT];
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= TOL_RESET;
      end else if (csr_valid) begin
         tol_ff <= csr_data;
      end
   end

   // input register
   logic signed [COMP_W-1:0] w_ff, x_ff, y_ff, z_ff;
   always_ff @(posedge clock) begin
      if (en[P_IN]) begin
         w_ff <= req_tdata[0*COMP_W +: COMP_W];
         x_ff <= req_tdata[1*COMP_W +: COMP_W];
         y_ff <= req_tdata[2*COMP_W +: COMP_W];
         z_ff <= req_tdata[3*COMP_W +: COMP_W];
      end
   end

   // products
   logic signed [PROD_W-1:0] ww_ff, xx_ff, yy_ff, zz_ff;
   logic signed [PROD_W-1:0] xy_ff, xz_ff, yz_ff, wx_ff, wy_ff, wz_ff;
   always_ff @(posedge clock) begin
      if (en[P_PROD]) begin
         ww_ff <= w_ff * w_ff;
         xx_ff <= x_ff * x_ff;
         yy_ff <= y_ff * y_ff;
         zz_ff <= z_ff * z_ff;
         xy_ff <= x_ff * y_ff;
         xz_ff <= x_ff * z_ff;
         yz_ff <= y_ff * z_ff;
         wx_ff <= w_ff * x_ff;
         wy_ff <= w_ff * y_ff;
         wz_ff <= w_ff * z_ff;
      end
   end

   // sums of squares and doubled cross terms
   num_type num_in, num_ff;
   always_comb begin
      num_in.s  = S_W'($unsigned(ww_ff)) + S_W'($unsigned(xx_ff))
                + S_W'($unsigned(yy_ff)) + S_W'($unsigned(zz_ff));
      num_in.a0 = S_W'($unsigned(yy_ff)) + S_W'($unsigned(zz_ff));
      num_in.a4 = S_W'($unsigned(xx_ff)) + S_W'($unsigned(zz_ff));
      num_in.a8 = S_W'($unsigned(xx_ff)) + S_W'($unsigned(yy_ff));
      num_in.o1 = (O_W'(xy_ff) - O_W'(wz_ff)) <<< 1;
      num_in.o2 = (O_W'(xz_ff) + O_W'(wy_ff)) <<< 1;
      num_in.o3 = (O_W'(xy_ff) + O_W'(wz_ff)) <<< 1;
      num_in.o5 = (O_W'(yz_ff) - O_W'(wx_ff)) <<< 1;
      num_in.o6 = (O_W'(xz_ff) - O_W'(wy_ff)) <<< 1;
      num_in.o7 = (O_W'(yz_ff) + O_W'(wx_ff)) <<< 1;
   end

   always_ff @(posedge clock) begin
      if (en[P_SUM]) begin
         num_ff <= num_in;
      end
   end

   // norm square root, one root bit per stage
   logic [SQ_IN_W-1:0]  sq_val_ff  [SQ_STEPS];
   logic [SQ_REM_W-1:0] sq_rem_ff  [SQ_STEPS];
   logic [SQ_STEPS-1:0] sq_root_ff [SQ_STEPS];
   num_type             sq_num_ff  [SQ_STEPS];

   for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sq
      logic [SQ_IN_W-1:0]  val_src;
      logic [SQ_REM_W-1:0] rem_src;
      logic [SQ_STEPS-1:0] root_src;
      num_type             num_src;
      logic [SQ_REM_W-1:0] rem_cat;
      logic [SQ_REM_W-1:0] trial;
      logic                ge;

      if (i == 0) begin : g_first
         assign val_src  = SQ_IN_W'(num_ff.s) << SQ_SHIFT;
         assign rem_src  = '0;
         assign root_src = '0;
         assign num_src  = num_ff;
      end else begin : g_next
         assign val_src  = sq_val_ff[i-1];
         assign rem_src  = sq_rem_ff[i-1];
         assign root_src = sq_root_ff[i-1];
         assign num_src  = sq_num_ff[i-1];
      end

      assign rem_cat = {rem_src[SQ_REM_W-3:0], val_src[SQ_IN_W-1 -: 2]};
      assign trial   = {root_src, 2'b01};
      assign ge      = rem_cat >= trial;

      always_ff @(posedge clock) begin
         if (en[P_SQ0+i]) begin
            sq_val_ff[i]  <= val_src << 2;
            sq_rem_ff[i]  <= ge ? rem_cat - trial : rem_cat;
            sq_root_ff[i] <= {root_src[SQ_STEPS-2:0], ge};
            sq_num_ff[i]  <= num_src;
         end
      end
   end

   // tolerance test picks the denominator
   num_type        cmp_num_ff;
   logic [D_W-1:0] cmp_d_ff;
   logic           cmp_zero_ff;
   logic [SQ_STEPS-1:0] nrm, one_q, diff;
   logic                by_sum;

   always_comb begin
      nrm    = sq_root_ff[SQ_STEPS-1];
      one_q  = SQ_STEPS'(1) << OUT_FRAC;
      diff   = (nrm > one_q) ? nrm - one_q : one_q - nrm;
      by_sum = diff > SQ_STEPS'(tol_ff);
   end

   always_ff @(posedge clock) begin
      if (en[P_CMP]) begin
         cmp_num_ff  <= sq_num_ff[SQ_STEPS-1];
         cmp_d_ff    <= by_sum ? sq_num_ff[SQ_STEPS-1].s : D_W'(1) << (2 * IN_FRAC);
         cmp_zero_ff <= sq_num_ff[SQ_STEPS-1].s == '0;
      end
   end

   // numerators, sign and clamped magnitude
   logic signed [E_W-1:0] ent_e [N_ENT];
   logic signed [E_W-1:0] d_ext;
   logic [D_W-1:0]   mag_ff [N_ENT];
   logic [D_W-1:0]   den_ff;
   side_type         num_side_ff;

   assign d_ext    = E_W'($signed({1'b0, cmp_d_ff}));
   assign ent_e[0] = d_ext - (E_W'($signed({1'b0, cmp_num_ff.a0})) <<< 1);
   assign ent_e[1] = E_W'(cmp_num_ff.o1);
   assign ent_e[2] = E_W'(cmp_num_ff.o2);
   assign ent_e[3] = E_W'(cmp_num_ff.o3);
   assign ent_e[4] = d_ext - (E_W'($signed({1'b0, cmp_num_ff.a4})) <<< 1);
   assign ent_e[5] = E_W'(cmp_num_ff.o5);
   assign ent_e[6] = E_W'(cmp_num_ff.o6);
   assign ent_e[7] = E_W'(cmp_num_ff.o7);
   assign ent_e[8] = d_ext - (E_W'($signed({1'b0, cmp_num_ff.a8})) <<< 1);

   for (genvar k = 0; k < N_ENT; k++) begin : g_num
      logic [E_W-1:0] abs_e;
      assign abs_e = ent_e[k][E_W-1] ? E_W'(-ent_e[k]) : E_W'(ent_e[k]);
      always_ff @(posedge clock) begin
         if (en[P_NUM]) begin
            mag_ff[k]          <= (abs_e > E_W'(cmp_d_ff)) ? cmp_d_ff : D_W'(abs_e);
            num_side_ff.sgn[k] <= ent_e[k][E_W-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[P_NUM]) begin
         den_ff           <= cmp_d_ff;
         num_side_ff.zero <= cmp_zero_ff;
      end
   end

   // dividers with sign and zero flag running alongside
   logic [Q_W-1:0] quo [N_ENT];
   side_type       div_side_ff [Q_W];

   for (genvar k = 0; k < N_ENT; k++) begin : g_div
      qrm_div_lane u_div (
         .clock (clock),
         .en    (en[P_DIV0 +: Q_W]),
         .mag   (mag_ff[k]),
         .den   (den_ff),
         .quo   (quo[k])
      );
   end

   for (genvar j = 0; j < Q_W; j++) begin : g_side
      always_ff @(posedge clock) begin
         if (en[P_DIV0+j]) begin
            div_side_ff[j] <= (j == 0) ? num_side_ff : div_side_ff[(j == 0) ? 0 : j-1];
         end
      end
   end

   // output register
   logic [ENT_W-1:0] ent_ff [N_ENT];
   logic             zero_ff;

   for (genvar k = 0; k < N_ENT; k++) begin : g_out
      logic [ENT_W-1:0] qx;
      assign qx = ENT_W'(quo[k]);
      always_ff @(posedge clock) begin
         if (en[P_OUT]) begin
            if (div_side_ff[Q_W-1].zero) begin
               ent_ff[k] <= '0;
            end else begin
               ent_ff[k] <= div_side_ff[Q_W-1].sgn[k] ? ENT_W'(-qx) : qx;
            end
         end
      end
      assign rsp_tdata[k*ENT_W +: ENT_W] = ent_ff[k];
   end

   always_ff @(posedge clock) begin
      if (en[P_OUT]) begin
         zero_ff <= div_side_ff[Q_W-1].zero;
      end
   end

   assign rsp_tuser = zero_ff;

endmodule
